[sv/e2q_pkg.sv]
// Package for the Euler-angle to quaternion converter: types, constants, arctangent table.
package e2q_pkg;

  localparam int CordicStages = 16;
  localparam int AngW = 34;
  localparam int XyW = 33;
  localparam int ScW = 22;
  localparam int QLim = 16384;

  localparam logic signed [AngW-1:0] PiQ30 = 34'sh0C90FDAA2;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sh06487ED51;
  localparam logic signed [XyW-1:0] GainQ30 = 33'sh026DD3B6A;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_item_t;

  // Per-angle rotator state.
  typedef struct packed {
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AngW-1:0] z;
    logic                   flip;
  } rot_t;

  typedef struct packed {
    rot_t r;
    rot_t p;
    rot_t w;
  } rot3_t;

  typedef struct packed {
    logic signed [ScW-1:0] sr;
    logic signed [ScW-1:0] cr;
    logic signed [ScW-1:0] sp;
    logic signed [ScW-1:0] cp;
    logic signed [ScW-1:0] sy;
    logic signed [ScW-1:0] cy;
  } sc_t;

  // atan(2^-i) in Q.30, rounded to nearest.
  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic [29:0] t;
    case (i)
      0:  t = 30'h3243F6A9;
      1:  t = 30'h1DAC6705;
      2:  t = 30'h0FADBAFD;
      3:  t = 30'h07F56EA7;
      4:  t = 30'h03FEAB77;
      5:  t = 30'h01FFD55C;
      6:  t = 30'h00FFFAAB;
      7:  t = 30'h007FFF55;
      8:  t = 30'h003FFFEB;
      9:  t = 30'h001FFFFD;
      10: t = 30'h00100000;
      11: t = 30'h00080000;
      12: t = 30'h00040000;
      13: t = 30'h00020000;
      14: t = 30'h00010000;
      15: t = 30'h00008000;
      16: t = 30'h00004000;
      17: t = 30'h00002000;
      18: t = 30'h00001000;
      19: t = 30'h00000800;
      20: t = 30'h00000400;
      21: t = 30'h00000200;
      22: t = 30'h00000100;
      23: t = 30'h00000080;
      default: t = '0;
    endcase
    return AngW'(signed'({1'b0, t}));
  endfunction

  // Round a Q.30 value to Q.20.
  function automatic logic signed [ScW-1:0] rnd20(input logic signed [XyW-1:0] v);
    logic signed [XyW:0] s;
    s = XyW'(v) + (XyW+1)'(512);
    s = {v[XyW-1], v} + (XyW+1)'(512);
    return ScW'(s >>> 10);
  endfunction

endpackage

[sv/e2q_cell.sv]
// One CORDIC micro-rotation cell acting on all three angles in lockstep.
module e2q_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         stage,
  input  logic               vin,
  input  logic               en,
  input  e2q_pkg::rot3_t     din,
  output logic               vout,
  output e2q_pkg::rot3_t     dout
);

  function automatic e2q_pkg::rot_t rot(input e2q_pkg::rot_t a, input logic [4:0] i);
    e2q_pkg::rot_t o;
    logic signed [e2q_pkg::XyW-1:0] dx, dy;
    logic signed [e2q_pkg::AngW-1:0] at;
    dx = a.y >>> i;
    dy = a.x >>> i;
    at = e2q_pkg::atan_q30(int'(i));
    o.flip = a.flip;
    if (!a.z[e2q_pkg::AngW-1]) begin
      o.x = a.x - dx; o.y = a.y + dy; o.z = a.z - at;
    end else begin
      o.x = a.x + dx; o.y = a.y - dy; o.z = a.z + at;
    end
    return o;
  endfunction

  // Advance one rotation step when the pipe moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r <= rot(din.r, stage);
      dout.p <= rot(din.p, stage);
      dout.w <= rot(din.w, stage);
    end
  end

endmodule

[sv/e2q_combine.sv]
// Product and sum stages that form the quaternion from the half-angle sines and cosines.
module e2q_combine (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  e2q_pkg::sc_t      sc,
  output logic              vout,
  output e2q_pkg::out_item_t q
);
  localparam int PW = 2 * e2q_pkg::ScW;
  localparam int TW = 3 * e2q_pkg::ScW;

  logic [1:0] v;
  logic signed [PW-1:0] cpcy, spsy, spcy, cpsy;
  logic signed [e2q_pkg::ScW-1:0] sr1, cr1;
  logic signed [TW-1:0] t0, t1, t2, t3, t4, t5, t6, t7;

  function automatic logic signed [15:0] q14(input logic signed [TW:0] s);
    logic signed [TW+1:0] r;
    r = {s[TW], s} + (TW+2)'(64'sd1 <<< 45);
    r = r >>> 46;
    if (r > (TW+2)'(e2q_pkg::QLim)) return 16'(e2q_pkg::QLim);
    if (r < -(TW+2)'(e2q_pkg::QLim)) return -16'(e2q_pkg::QLim);
    return r[15:0];
  endfunction

  // Valid tracking for the two multiply stages and the sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      vout <= 1'b0;
    end else if (en) begin
      v <= {v[0], vin};
      vout <= v[1];
    end
  end

  // Pair products of pitch and yaw, then triple products with roll, then sums.
  always_ff @(posedge clk) begin
    if (en) begin
      cpcy <= sc.cp * sc.cy;
      spsy <= sc.sp * sc.sy;
      spcy <= sc.sp * sc.cy;
      cpsy <= sc.cp * sc.sy;
      sr1 <= sc.sr;
      cr1 <= sc.cr;
      t0 <= sr1 * cpcy; t1 <= cr1 * spsy;
      t2 <= cr1 * spcy; t3 <= sr1 * cpsy;
      t4 <= cr1 * cpsy; t5 <= sr1 * spcy;
      t6 <= cr1 * cpcy; t7 <= sr1 * spsy;
      q.quat_x <= q14({t0[TW-1], t0} - {t1[TW-1], t1});
      q.quat_y <= q14({t2[TW-1], t2} + {t3[TW-1], t3});
      q.quat_z <= q14({t4[TW-1], t4} - {t5[TW-1], t5});
      q.quat_w <= q14({t6[TW-1], t6} + {t7[TW-1], t7});
    end
  end

endmodule

[sv/euler_to_quaternion.sv]
// Top level: Euler angles (ZYX) to quaternion through a CORDIC cell chain.
//   channel | signals                      | payload
//   in      | in_valid, in_ready, in_data  | roll, pitch, yaw Q3.12
//   out     | out_valid, out_ready, out_data | quat x, y, z, w Q1.14
// One transaction per cycle while the output is not stalled; the path runs through the
// range-reduce register, one cell per stage, rounding, and three product/sum stages.
// Synchronous reset clears valid bits only. A stalled output freezes the whole chain.
module euler_to_quaternion (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  e2q_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output e2q_pkg::out_item_t   out_data
);
  localparam int N = e2q_pkg::CordicStages;

  logic en;
  logic v0, vr;
  e2q_pkg::rot3_t r0;
  e2q_pkg::rot3_t chain [N+1];
  logic vc [N+1];
  e2q_pkg::sc_t sc;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  function automatic e2q_pkg::rot_t reduce(input logic signed [15:0] a);
    e2q_pkg::rot_t o;
    logic signed [e2q_pkg::AngW-1:0] z;
    z = e2q_pkg::AngW'(a) <<< 17;
    o.x = e2q_pkg::GainQ30;
    o.y = '0;
    o.flip = 1'b0;
    o.z = z;
    if (z > e2q_pkg::HalfPiQ30) begin
      o.z = z - e2q_pkg::PiQ30; o.flip = 1'b1;
    end else if (z < -e2q_pkg::HalfPiQ30) begin
      o.z = z + e2q_pkg::PiQ30; o.flip = 1'b1;
    end
    return o;
  endfunction

  function automatic logic signed [e2q_pkg::XyW-1:0] fl(input logic signed [e2q_pkg::XyW-1:0] v,
                                                     input logic f);
    return f ? -v : v;
  endfunction

  // Capture and range-reduce the input angles.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0.r <= reduce(in_data.roll_angle);
      r0.p <= reduce(in_data.pitch_angle);
      r0.w <= reduce(in_data.yaw_angle);
    end
  end

  assign chain[0] = r0;
  assign vc[0] = v0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk), .rst(rst), .stage(5'(i)), .vin(vc[i]), .en(en),
      .din(chain[i]), .vout(vc[i+1]), .dout(chain[i+1])
    );
  end

  // Undo the half-turn fold and round to Q.20.
  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vc[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.sr <= e2q_pkg::rnd20(fl(chain[N].r.y, chain[N].r.flip));
      sc.cr <= e2q_pkg::rnd20(fl(chain[N].r.x, chain[N].r.flip));
      sc.sp <= e2q_pkg::rnd20(fl(chain[N].p.y, chain[N].p.flip));
      sc.cp <= e2q_pkg::rnd20(fl(chain[N].p.x, chain[N].p.flip));
      sc.sy <= e2q_pkg::rnd20(fl(chain[N].w.y, chain[N].w.flip));
      sc.cy <= e2q_pkg::rnd20(fl(chain[N].w.x, chain[N].w.flip));
    end
  end

  e2q_combine u_combine (
    .clk(clk), .rst(rst), .en(en), .vin(vr), .sc(sc), .vout(out_valid), .q(out_data)
  );

`ifndef SYNTHESIS
  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // The quat_w component stays within saturation bounds.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384)
    else $error("quat_w out of range");
  // The input is ready whenever no result is pending.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stall without pending result");
`endif

endmodule

[tb/euler_to_quaternion_tb.sv]
// Testbench for the Euler-angle to quaternion converter: directed table, random angles, predictor.
module euler_to_quaternion_tb;

  localparam int Latency = e2q_pkg::CordicStages + 5;
  localparam int StallLimit = 3000;
  localparam int RandomItems = 1750;
  localparam int QuietTail = 200;
  localparam longint PiFix = 64'h0C90FDAA2;
  localparam longint HalfPiFix = 64'h06487ED51;
  localparam longint GainFix = 64'h026DD3B6A;

  typedef struct {
    e2q_pkg::in_item_t  angles;
    bit                 typed;
    e2q_pkg::out_item_t quat;
  } angle_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  e2q_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  e2q_pkg::out_item_t out_data;

  e2q_pkg::out_item_t quat_fifo[$];
  longint             atan_lut[24];
  int                 mismatches;
  int                 quiet_cycles;
  bit                 feed_done;
  bit                 no_idle;
  angle_row_t         angle_rows[$];

  euler_to_quaternion DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // atan(2^-i) in Q.30 from its power series in Q.62
  function automatic longint arctan_fix(int i);
    longint unsigned pos, neg, t;
    int sh;
    pos = 0;
    neg = 0;
    if (i == 0) return 64'h3243F6A9;
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh >= 62) break;
      t = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
      if (k % 2) neg += t;
      else pos += t;
    end
    return longint'((pos - neg + (64'd1 << 31)) >> 32);
  endfunction

  // Sine and cosine of half a Q3.12 angle, Q.20
  function automatic void half_sin_cos(input logic signed [15:0] ang, output longint s,
                                       output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * (64'sd1 <<< 17);
    x = GainFix;
    y = 0;
    flip = 0;
    if (z > HalfPiFix) begin
      z -= PiFix;
      flip = 1;
    end else if (z < -HalfPiFix) begin
      z += PiFix;
      flip = 1;
    end
    for (int i = 0; i < e2q_pkg::CordicStages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 512) >>> 10;
    s = (y + 512) >>> 10;
  endfunction

  function automatic logic signed [15:0] round_q14(longint v);
    longint r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > e2q_pkg::QLim) r = e2q_pkg::QLim;
    if (r < -e2q_pkg::QLim) r = -e2q_pkg::QLim;
    return 16'(r);
  endfunction

  function automatic e2q_pkg::out_item_t predict_quat(e2q_pkg::in_item_t a);
    longint sr, cr, sp, cp, sy, cy;
    e2q_pkg::out_item_t q;
    half_sin_cos(a.roll_angle, sr, cr);
    half_sin_cos(a.pitch_angle, sp, cp);
    half_sin_cos(a.yaw_angle, sy, cy);
    q.quat_x = round_q14(sr * cp * cy - cr * sp * sy);
    q.quat_y = round_q14(cr * sp * cy + sr * cp * sy);
    q.quat_z = round_q14(cr * cp * sy - sr * sp * cy);
    q.quat_w = round_q14(cr * cp * cy + sr * sp * sy);
    return q;
  endfunction

  // Record predictions, compare results, watch for a hang
  always @(posedge clk) begin
    e2q_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) quat_fifo = {quat_fifo, predict_quat(in_data)};
      if (out_valid && out_ready) begin
        if (quat_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", out_data);
        end else begin
          want = quat_fifo.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("quat mismatch: x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d (exp/got)",
                       want.quat_x, out_data.quat_x, want.quat_y, out_data.quat_y,
                       want.quat_z, out_data.quat_z, want.quat_w, out_data.quat_w);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || feed_done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Output back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  function automatic angle_row_t mk_row(int r, int p, int y, bit typed = 0,
                                        int qx = 0, int qy = 0, int qz = 0, int qw = 0);
    angle_row_t row;
    row.angles = '{16'(r), 16'(p), 16'(y)};
    row.typed = typed;
    row.quat = '{16'(qx), 16'(qy), 16'(qz), 16'(qw)};
    return row;
  endfunction

  // Append one row to the stimulus table
  function automatic void add_row(angle_row_t row);
    angle_rows = {angle_rows, row};
  endfunction

  // Present one angle triple and hold it until taken
  task automatic send_angles(e2q_pkg::in_item_t a);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    e2q_pkg::in_item_t a;
    int got;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    feed_done = 0;
    no_idle = 0;
    for (int i = 0; i < 24; i++) atan_lut[i] = arctan_fix(i);
    // Directed rows: zero, extremes, half-turn fold boundaries, small angles
    add_row(mk_row(0, 0, 0, 1, 0, 0, 0, 16384));
    add_row(mk_row(32767, 32767, 32767));
    add_row(mk_row(-32768, -32768, -32768));
    add_row(mk_row(32767, 0, 0));
    add_row(mk_row(-32768, 0, 0));
    add_row(mk_row(0, 32767, 0));
    add_row(mk_row(0, -32768, 0));
    add_row(mk_row(0, 0, 32767));
    add_row(mk_row(0, 0, -32768));
    add_row(mk_row(12867, 12868, 12869));
    add_row(mk_row(-12867, -12868, -12869));
    add_row(mk_row(12868, -12868, 25736));
    add_row(mk_row(6434, 6434, 6434));
    add_row(mk_row(1, -1, 1));
    add_row(mk_row(-1, 1, -1));
    add_row(mk_row(16'h5555, 16'hAAAA, 16'h5555));
    add_row(mk_row(16'hAAAA, 16'h5555, 16'hAAAA));
    add_row(mk_row(-25736, 25736, -6434));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (angle_rows[i]) begin
      send_angles(angle_rows[i].angles);
      if (angle_rows[i].typed && predict_quat(angle_rows[i].angles) !== angle_rows[i].quat) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with its typed result", i);
      end
    end
    // Random angles; mostly the full range, some near the fold points
    for (int n = 0; n < RandomItems; n++) begin
      if (n >= RandomItems - QuietTail) no_idle = 1;
      if ($urandom_range(0, 4) == 0) begin
        a.roll_angle = 16'($urandom_range(12860, 12876) * ($urandom_range(0, 1) ? 1 : -1));
        a.pitch_angle = 16'($urandom_range(12860, 12876) * ($urandom_range(0, 1) ? 1 : -1));
        a.yaw_angle = 16'($urandom);
      end else begin
        a = e2q_pkg::in_item_t'(48'({$urandom, $urandom}));
      end
      send_angles(a);
    end
    in_valid <= 1'b0;
    feed_done = 1;
    got = 0;
    while (quat_fifo.size() != 0 && got < StallLimit) begin
      @(posedge clk);
      got++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && quat_fifo.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/e2q_pkg.sv
sv/e2q_cell.sv
sv/e2q_combine.sv
sv/euler_to_quaternion.sv
tb/euler_to_quaternion_tb.sv
